/* src/abdd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdd_pkg
// Shared constants, register codes and the exp2 table for the anchor box
// delta decoder.
// ----------------------------------------------------------------------------
package abdd_pkg;

    localparam int COORD_WIDTH_DEF     = 20;
    localparam int DELTA_FRAC_BITS_DEF = 12;

    localparam int DELTA_W    = 16;
    localparam int SCORE_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int SCALE_FRAC = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_CLIP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SCALE  = 3'd4;

    localparam logic signed [DELTA_W-1:0] DELTA_CLIP_RST  = 16'sd16937;
    localparam logic [SCALE_W-1:0]        IMAGE_SCALE_RST = 16'd256;

    localparam logic signed [SCORE_W-1:0] SCORE_DROP = 16'sh8000;

    // exp approximation
    localparam int LOG2E_Q16  = 94548;
    localparam int LOG2E_W    = 17;
    localparam int LN2_Q16    = 45426;
    localparam int LN2_W      = 16;
    localparam int TAB_W      = 17;
    localparam int TAB_IDX_W  = 4;
    localparam int FRAC_LO_W  = 12;
    localparam int CORR_SHIFT = 32;

    localparam int SHIFT_SAT_MAX  = 20;
    localparam int SHIFT_ZERO_MIN = -40;
    localparam int PW_SAT_BIT     = 60;

    localparam int AXIS_STAGES  = 8;
    localparam int TOTAL_STAGES = AXIS_STAGES + 1;

    // 2^(j/16) in Q.16
    function automatic logic [TAB_W-1:0] exp2_tab(input logic [TAB_IDX_W-1:0] j);
        logic [TAB_W-1:0] v;
        case (j)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd68438;
            4'd2:    v = 17'd71468;
            4'd3:    v = 17'd74632;
            4'd4:    v = 17'd77936;
            4'd5:    v = 17'd81386;
            4'd6:    v = 17'd84990;
            4'd7:    v = 17'd88752;
            4'd8:    v = 17'd92682;
            4'd9:    v = 17'd96785;
            4'd10:   v = 17'd101070;
            4'd11:   v = 17'd105545;
            4'd12:   v = 17'd110218;
            4'd13:   v = 17'd115098;
            4'd14:   v = 17'd120194;
            4'd15:   v = 17'd125515;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

/* src/abdd_box_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdd_box_if
// Input channel: one anchor box, its four deltas and the score per word.
// ----------------------------------------------------------------------------
interface abdd_box_if import abdd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] anchor_left;
    logic signed [COORD_WIDTH-1:0] anchor_top;
    logic signed [COORD_WIDTH-1:0] anchor_right;
    logic signed [COORD_WIDTH-1:0] anchor_bottom;
    logic signed [DELTA_W-1:0]     delta_x;
    logic signed [DELTA_W-1:0]     delta_y;
    logic signed [DELTA_W-1:0]     delta_w;
    logic signed [DELTA_W-1:0]     delta_h;
    logic signed [SCORE_W-1:0]     score_in;

    modport source (
        output valid, anchor_left, anchor_top, anchor_right, anchor_bottom,
               delta_x, delta_y, delta_w, delta_h, score_in,
        input  ready
    );

    modport sink (
        input  valid, anchor_left, anchor_top, anchor_right, anchor_bottom,
               delta_x, delta_y, delta_w, delta_h, score_in,
        output ready
    );
endinterface

/* src/abdd_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdd_res_if
// Result channel: one clamped decoded box, score and keep flag per word.
// ----------------------------------------------------------------------------
interface abdd_res_if import abdd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                      valid;
    logic                      ready;
    logic [COORD_WIDTH-2:0]    box_left;
    logic [COORD_WIDTH-2:0]    box_top;
    logic [COORD_WIDTH-2:0]    box_right;
    logic [COORD_WIDTH-2:0]    box_bottom;
    logic signed [SCORE_W-1:0] score_out;
    logic                      kept;

    modport source (
        output valid, box_left, box_top, box_right, box_bottom, score_out, kept,
        input  ready
    );

    modport sink (
        input  valid, box_left, box_top, box_right, box_bottom, score_out, kept,
        output ready
    );
endinterface

/* src/abdd_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdd_axis
// One axis of the box decode: size, centre shift, exp scaling of the size,
// rounding and clamping of both corners. Eight register stages, each loaded
// by its own enable from the top level.
// ----------------------------------------------------------------------------
module abdd_axis import abdd_pkg::*; #(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int DELTA_FRAC_BITS = DELTA_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [AXIS_STAGES-1:0]        i_en,
    input  logic signed [COORD_WIDTH-1:0] i_lo,
    input  logic signed [COORD_WIDTH-1:0] i_hi,
    input  logic signed [DELTA_W-1:0]     i_shift,
    input  logic signed [DELTA_W-1:0]     i_scale,
    input  logic signed [DELTA_W-1:0]     i_clip,
    input  logic [COORD_WIDTH-2:0]        i_limit,
    output logic [COORD_WIDTH-2:0]        o_lo,
    output logic [COORD_WIDTH-2:0]        o_hi
);

    localparam int CW     = COORD_WIDTH;
    localparam int S      = DELTA_FRAC_BITS;
    localparam int FS     = S + TAB_IDX_W + FRAC_LO_W;
    localparam int T_W    = DELTA_W + LOG2E_W + 1;
    localparam int K_W    = (T_W - FS + 3 > 8) ? T_W - FS + 3 : 8;
    localparam int SD_W   = CW + DELTA_W;
    localparam int CB_W   = CW + S + 1;
    localparam int C_W    = ((CB_W > SD_W) ? CB_W : SD_W) + 1;
    localparam int TR_W   = TAB_W + FRAC_LO_W;
    localparam int CP_W   = TR_W + LN2_W;
    localparam int CA_W   = CP_W - CORR_SHIFT;
    localparam int M_W    = TAB_W + 1;
    localparam int PROD_W = CW + M_W;
    localparam int SH_W   = (PROD_W + SHIFT_SAT_MAX + 1 > PW_SAT_BIT + 2) ?
                            PROD_W + SHIFT_SAT_MAX + 1 : PW_SAT_BIT + 2;
    localparam int PM_W   = PW_SAT_BIT + 1;
    localparam int P_W    = PW_SAT_BIT + 2;
    localparam int SUM_W  = ((C_W + 1 > P_W) ? C_W + 1 : P_W) + 2;

    localparam logic signed [CW-1:0]      SIZE_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]      SIZE_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [LOG2E_W:0]   LOG2E_S   = (LOG2E_W + 1)'(LOG2E_Q16);
    localparam logic signed [K_W-1:0]     K_SAT     = K_W'(SHIFT_SAT_MAX);
    localparam logic signed [K_W-1:0]     K_ZERO    = K_W'(SHIFT_ZERO_MIN);
    localparam logic signed [K_W-1:0]     K_OFS     = K_W'(S - 16);
    localparam logic [PM_W-1:0]           P_SAT     = {1'b1, {(PM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]   HALF_LSB  = SUM_W'(2 ** S);

    function automatic logic [CW-2:0] clamp(input logic signed [SUM_W-1:0] v,
                                            input logic [CW-2:0] lim);
        logic [CW-2:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (v > $signed(SUM_W'(lim))) begin
            res = lim;
        end else begin
            res = v[CW-2:0];
        end
        return res;
    endfunction

    // ---- stage 0: saturated size, capped scale delta
    logic signed [CW:0]        s0_diff;
    logic signed [CW-1:0]      s0_size;
    logic signed [DELTA_W-1:0] s0_e;

    logic signed [CW-1:0]      r0_lo;
    logic signed [CW-1:0]      r0_size;
    logic signed [DELTA_W-1:0] r0_d;
    logic signed [DELTA_W-1:0] r0_e;

    always_comb begin
        s0_diff = {i_hi[CW-1], i_hi} - {i_lo[CW-1], i_lo};
        if (s0_diff[CW] != s0_diff[CW-1]) begin
            s0_size = s0_diff[CW] ? SIZE_MIN : SIZE_MAX;
        end else begin
            s0_size = s0_diff[CW-1:0];
        end
        s0_e = (i_scale > i_clip) ? i_clip : i_scale;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_lo   <= i_lo;
            r0_size <= s0_size;
            r0_d    <= i_shift;
            r0_e    <= s0_e;
        end
    end

    // ---- stage 1: log2 scaling, size * shift, centre base
    logic signed [T_W-1:0]  s1_t;
    logic signed [SD_W-1:0] s1_sd;
    logic signed [CB_W-1:0] s1_cb;

    logic signed [T_W-1:0]  r1_t;
    logic [CW-1:0]          r1_mag;
    logic                   r1_neg;
    logic signed [SD_W-1:0] r1_sd;
    logic signed [CB_W-1:0] r1_cb;

    assign s1_t  = r0_e * LOG2E_S;
    assign s1_sd = r0_size * r0_d;
    assign s1_cb = (CB_W'(r0_lo) <<< S) + (CB_W'(r0_size) <<< (S - 1));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_t   <= s1_t;
            r1_mag <= r0_size[CW-1] ? CW'(-r0_size) : CW'(r0_size);
            r1_neg <= r0_size[CW-1];
            r1_sd  <= s1_sd;
            r1_cb  <= s1_cb;
        end
    end

    // ---- stage 2: split exponent into integer shift and table index, centre sum, table * fraction
    logic [TAB_W-1:0]       s2_tj;
    logic [FRAC_LO_W-1:0]   s2_r;

    logic signed [C_W-1:0]  r2_c;
    logic signed [K_W-1:0]  r2_k;
    logic [TAB_W-1:0]       r2_tj;
    logic [TR_W-1:0]        r2_tr;
    logic [CW-1:0]          r2_mag;
    logic                   r2_neg;

    assign s2_tj = exp2_tab(r1_t[FS-1:FS-TAB_IDX_W]);
    assign s2_r  = r1_t[S+FRAC_LO_W-1:S];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_c   <= C_W'(r1_cb) + C_W'(r1_sd);
            r2_k   <= K_W'($signed(r1_t[T_W-1:FS])) + K_OFS;
            r2_tj  <= s2_tj;
            r2_tr  <= TR_W'(s2_tj) * TR_W'(s2_r);
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
        end
    end

    // ---- stage 3: linear correction term
    logic [CP_W-1:0]        s3_cp;

    logic signed [C_W-1:0]  r3_c;
    logic signed [K_W-1:0]  r3_k;
    logic [TAB_W-1:0]       r3_tj;
    logic [CA_W-1:0]        r3_cadd;
    logic [CW-1:0]          r3_mag;
    logic                   r3_neg;

    assign s3_cp = CP_W'(r2_tr) * CP_W'(LN2_Q16);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_c    <= r2_c;
            r3_k    <= r2_k;
            r3_tj   <= r2_tj;
            r3_cadd <= s3_cp[CP_W-1:CORR_SHIFT];
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
        end
    end

    // ---- stage 4: mantissa
    logic signed [C_W-1:0]  r4_c;
    logic signed [K_W-1:0]  r4_k;
    logic [M_W-1:0]         r4_m;
    logic [CW-1:0]          r4_mag;
    logic                   r4_neg;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_c   <= r3_c;
            r4_k   <= r3_k;
            r4_m   <= M_W'(r3_tj) + M_W'(r3_cadd);
            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
        end
    end

    // ---- stage 5: |size| * mantissa
    logic signed [C_W-1:0]  r5_c;
    logic signed [K_W-1:0]  r5_k;
    logic [PROD_W-1:0]      r5_prod;
    logic                   r5_neg;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_c    <= r4_c;
            r5_k    <= r4_k;
            r5_prod <= PROD_W'(r4_mag) * PROD_W'(r4_m);
            r5_neg  <= r4_neg;
        end
    end

    // ---- stage 6: power-of-two shift with saturation, restore sign
    logic [SH_W-1:0]        s6_shl;
    logic [PROD_W-1:0]      s6_shr;
    logic signed [K_W-1:0]  s6_nk;
    logic [PM_W-1:0]        s6_mag;
    logic signed [P_W-1:0]  s6_p;

    logic signed [C_W-1:0]  r6_c;
    logic signed [P_W-1:0]  r6_p;

    always_comb begin
        s6_nk  = -r5_k;
        s6_shl = SH_W'(r5_prod) << r5_k[4:0];
        s6_shr = r5_prod >> s6_nk[5:0];
        if (r5_prod == '0) begin
            s6_mag = '0;
        end else if (r5_k > K_SAT) begin
            s6_mag = P_SAT;
        end else if (!r5_k[K_W-1]) begin
            if (|s6_shl[SH_W-1:PW_SAT_BIT]) begin
                s6_mag = P_SAT;
            end else begin
                s6_mag = PM_W'(s6_shl[PW_SAT_BIT-1:0]);
            end
        end else if (r5_k < K_ZERO) begin
            s6_mag = '0;
        end else begin
            s6_mag = PM_W'(s6_shr);
        end
        s6_p = r5_neg ? -$signed({1'b0, s6_mag}) : $signed({1'b0, s6_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_c <= r5_c;
            r6_p <= s6_p;
        end
    end

    // ---- stage 7: corners, round half up, clamp
    logic signed [SUM_W-1:0] s7_c2;
    logic signed [SUM_W-1:0] s7_lo_num;
    logic signed [SUM_W-1:0] s7_hi_num;
    logic signed [SUM_W-1:0] s7_lo_q;
    logic signed [SUM_W-1:0] s7_hi_q;

    logic [CW-2:0]           r7_lo;
    logic [CW-2:0]           r7_hi;

    always_comb begin
        s7_c2     = SUM_W'(r6_c) <<< 1;
        s7_lo_num = s7_c2 - SUM_W'(r6_p) + HALF_LSB;
        s7_hi_num = s7_c2 + SUM_W'(r6_p) + HALF_LSB;
        s7_lo_q   = s7_lo_num >>> (S + 1);
        s7_hi_q   = s7_hi_num >>> (S + 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_lo <= clamp(s7_lo_q, i_limit);
            r7_hi <= clamp(s7_hi_q, i_limit);
        end
    end

    assign o_lo = r7_lo;
    assign o_hi = r7_hi;

endmodule

/* src/anchor_box_delta_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_box_delta_decode
// Decodes an anchor box and its regression deltas into a clamped box and
// applies the minimum-size keep test to the score.
//
//   channel    dir   handshake          word
//   i_box      in    valid / ready      anchor corners, four deltas, score
//   o_res      out   valid / ready      clamped box, score, keep flag
//   i_cfg_*    in    write enable only  register index + data
//
// One word per cycle sustained while o_res is ready. A word accepted at one edge shows on o_res
// after nine register stages: eight in each axis unit (two multiplier
// chains for the exp scaling) and one for the keep test.
// Each stage has its own valid bit and loads whenever it is empty or the next
// stage moves, so bubbles close up and a stall at o_res backs up stage by
// stage. Synchronous reset clears the valid bits and loads the config
// registers with their defaults.
// ----------------------------------------------------------------------------
module anchor_box_delta_decode import abdd_pkg::*; #(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int DELTA_FRAC_BITS = DELTA_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    abdd_box_if.sink              i_box,
    abdd_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [((COORD_WIDTH-1 > DELTA_W) ? COORD_WIDTH-1 : DELTA_W)-1:0] i_cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int LAST   = TOTAL_STAGES - 1;
    localparam int AREA_W = CW - 1 + SCALE_W;
    localparam int CMP_W  = CW + SCALE_W;

    // ---- configuration
    logic signed [DELTA_W-1:0] r_delta_clip;
    logic [CW-2:0]             r_min_side;
    logic [CW-2:0]             r_image_height;
    logic [CW-2:0]             r_image_width;
    logic [SCALE_W-1:0]        r_image_scale;
    logic [AREA_W-1:0]         r_min_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_clip   <= DELTA_CLIP_RST;
            r_min_side     <= '0;
            r_image_height <= '0;
            r_image_width  <= '0;
            r_image_scale  <= IMAGE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELTA_CLIP:   r_delta_clip   <= i_cfg_data[DELTA_W-1:0];
                CFG_MIN_SIDE:     r_min_side     <= i_cfg_data[CW-2:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[CW-2:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[CW-2:0];
                CFG_IMAGE_SCALE:  r_image_scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // user keeps config static between words (not enforced); one registered product is enough
    always_ff @(posedge i_clk) begin
        r_min_area <= AREA_W'(r_min_side) * AREA_W'(r_image_scale);
    end

    // ---- stage flow control
    logic [TOTAL_STAGES-1:0] r_vld;
    logic [TOTAL_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[LAST] = !r_vld[LAST] || o_res.ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !r_vld[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_box.valid;
            end
            for (int i = 1; i < TOTAL_STAGES; i++) begin
                if (stage_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign i_box.ready = stage_en[0];

    // ---- score travels alongside the axis units
    logic signed [SCORE_W-1:0] r_score [AXIS_STAGES];

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_score[0] <= i_box.score_in;
        end
        for (int i = 1; i < AXIS_STAGES; i++) begin
            if (stage_en[i]) begin
                r_score[i] <= r_score[i-1];
            end
        end
    end

    // ---- axis units
    logic [CW-2:0] x_lo, x_hi, y_lo, y_hi;

    abdd_axis #(
        .COORD_WIDTH     (COORD_WIDTH),
        .DELTA_FRAC_BITS (DELTA_FRAC_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (stage_en[AXIS_STAGES-1:0]),
        .i_lo    (i_box.anchor_left),
        .i_hi    (i_box.anchor_right),
        .i_shift (i_box.delta_x),
        .i_scale (i_box.delta_w),
        .i_clip  (r_delta_clip),
        .i_limit (r_image_width),
        .o_lo    (x_lo),
        .o_hi    (x_hi)
    );

    abdd_axis #(
        .COORD_WIDTH     (COORD_WIDTH),
        .DELTA_FRAC_BITS (DELTA_FRAC_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (stage_en[AXIS_STAGES-1:0]),
        .i_lo    (i_box.anchor_top),
        .i_hi    (i_box.anchor_bottom),
        .i_shift (i_box.delta_y),
        .i_scale (i_box.delta_h),
        .i_clip  (r_delta_clip),
        .i_limit (r_image_height),
        .o_lo    (y_lo),
        .o_hi    (y_hi)
    );

    // ---- keep test and output register
    logic signed [CW-1:0]    side_w;
    logic signed [CW-1:0]    side_h;
    logic signed [CW-1:0]    side_min;
    logic signed [CMP_W-1:0] side_scaled;
    logic                    keep;

    logic [CW-2:0]             r_box_left;
    logic [CW-2:0]             r_box_top;
    logic [CW-2:0]             r_box_right;
    logic [CW-2:0]             r_box_bottom;
    logic signed [SCORE_W-1:0] r_score_out;
    logic                      r_kept;

    always_comb begin
        side_w      = $signed({1'b0, x_hi}) - $signed({1'b0, x_lo});
        side_h      = $signed({1'b0, y_hi}) - $signed({1'b0, y_lo});
        side_min    = (side_w < side_h) ? side_w : side_h;
        side_scaled = CMP_W'(side_min) <<< SCALE_FRAC;
        keep        = side_scaled >= $signed(CMP_W'(r_min_area));
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[LAST]) begin
            r_box_left   <= x_lo;
            r_box_top    <= y_lo;
            r_box_right  <= x_hi;
            r_box_bottom <= y_hi;
            r_score_out  <= keep ? r_score[AXIS_STAGES-1] : SCORE_DROP;
            r_kept       <= keep;
        end
    end

    assign o_res.valid      = r_vld[LAST];
    assign o_res.box_left   = r_box_left;
    assign o_res.box_top    = r_box_top;
    assign o_res.box_right  = r_box_right;
    assign o_res.box_bottom = r_box_bottom;
    assign o_res.score_out  = r_score_out;
    assign o_res.kept       = r_kept;

endmodule
